// ===== design/swl_pkg.sv =====
package swl_pkg;

    localparam int unsigned STEP_SLOTS = 20;

    localparam int unsigned FUNC_W  = 3;
    localparam int unsigned INDEX_W = 5;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned REQ_W   = 10;
    localparam int unsigned STEP_W  = 6;
    localparam int unsigned COUNT_W = 5;
    localparam int unsigned TOL_W   = 31;

    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(305);

    typedef enum logic [FUNC_W-1:0] {
        FUNC_WRITE_ENTRY = 3'd0,
        FUNC_SET_LENGTH  = 3'd1,
        FUNC_START       = 3'd2,
        FUNC_STOP        = 3'd3,
        FUNC_SAMPLE      = 3'd4
    } func_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_NEXT
    } state_t;

endpackage

// ===== design/setpoint_list_walker.sv =====
// Setpoint list walker. A transaction is taken when start is high and busy is low;
// every transaction yields exactly one result, shown for one cycle with done high,
// and the receiver cannot stall it. An accepted transaction does one table read,
// then evaluates in ST_EVAL; a sample that reaches its target and moves on
// does a second read through the step table's one read port and shows its
// setpoint from ST_NEXT. busy stays high until done, so the block accepts a
// new transaction in the cycle done is shown, and none while one is in flight.
// The tolerance register may be written whenever the block is idle;
// cfg_ready is always high. No clearing pass follows reset.
module setpoint_list_walker (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                start,
    output logic                                busy,
    input  logic [swl_pkg::FUNC_W-1:0]          func,
    input  logic [swl_pkg::INDEX_W-1:0]         entry_index,
    input  logic signed [swl_pkg::VALUE_W-1:0]  value,
    input  logic [swl_pkg::REQ_W-1:0]           length_request,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [swl_pkg::TOL_W-1:0]           cfg_data,

    output logic                                done,
    output logic                                setpoint_valid,
    output logic signed [swl_pkg::VALUE_W-1:0]  setpoint,
    output logic signed [swl_pkg::STEP_W-1:0]   step_number,
    output logic                                walking,
    output logic                                start_allowed,
    output logic                                stop_allowed,
    output logic [swl_pkg::COUNT_W-1:0]         list_length,
    output logic                                rejected
);

    localparam int unsigned VW = swl_pkg::VALUE_W;
    localparam int unsigned SW = swl_pkg::STEP_W;
    localparam int unsigned CW = swl_pkg::COUNT_W;
    localparam int unsigned IW = swl_pkg::INDEX_W;

    swl_pkg::state_t state_reg, state_next;

    logic [swl_pkg::TOL_W-1:0]  tol_reg;
    logic [CW-1:0]              count_reg, count_next;
    logic signed [SW-1:0]       ptr_reg, ptr_next;
    logic                       walk_reg, walk_next;
    logic                       done_reg, done_next;
    logic                       sp_valid_reg, sp_valid_next;
    logic [VW-1:0]              sp_reg, sp_next;
    logic                       rej_reg, rej_next;

    logic [swl_pkg::FUNC_W-1:0] func_reg;
    logic [IW-1:0]              idx_reg;
    logic [VW-1:0]              value_reg;
    logic [swl_pkg::REQ_W-1:0]  req_reg;

    logic [VW-1:0]              step_mem [swl_pkg::STEP_SLOTS];
    logic [VW-1:0]              rd_data_reg;
    logic                       mem_re;
    logic [IW-1:0]              mem_raddr;
    logic                       mem_we;

    logic                       accept;
    logic signed [VW:0]         diff;
    logic [VW:0]                diff_abs;
    logic                       reached;
    logic signed [SW-1:0]       ptr_inc;
    logic                       has_next;
    logic [CW-1:0]              len_sat;

    assign accept    = start && (state_reg == swl_pkg::ST_IDLE);
    assign busy      = (state_reg != swl_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;

    assign diff     = $signed({value_reg[VW-1], value_reg})
                    - $signed({rd_data_reg[VW-1], rd_data_reg});
    assign diff_abs = diff[VW] ? (VW+1)'(-diff) : diff;
    assign reached  = (diff_abs <= {2'b00, tol_reg});
    assign ptr_inc  = ptr_reg + SW'(1);
    assign has_next = (ptr_inc < $signed({1'b0, count_reg}));
    assign len_sat  = (req_reg > swl_pkg::REQ_W'(swl_pkg::STEP_SLOTS))
                    ? CW'(swl_pkg::STEP_SLOTS) : req_reg[CW-1:0];

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            step_mem[idx_reg] <= value_reg;
        end
        if (mem_re)
        begin
            rd_data_reg <= step_mem[mem_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg  <= func;
            idx_reg   <= entry_index;
            value_reg <= value;
            req_reg   <= length_request;
        end
        sp_reg <= sp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= swl_pkg::ST_IDLE;
            tol_reg      <= swl_pkg::TOL_RESET;
            count_reg    <= '0;
            ptr_reg      <= -SW'(1);
            walk_reg     <= 1'b0;
            done_reg     <= 1'b0;
            sp_valid_reg <= 1'b0;
            rej_reg      <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            ptr_reg      <= ptr_next;
            walk_reg     <= walk_next;
            done_reg     <= done_next;
            sp_valid_reg <= sp_valid_next;
            rej_reg      <= rej_next;
            if (cfg_valid && cfg_ready)
            begin
                tol_reg <= cfg_data;
            end
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        ptr_next      = ptr_reg;
        walk_next     = walk_reg;
        done_next     = 1'b0;
        sp_valid_next = sp_valid_reg;
        sp_next       = sp_reg;
        rej_next      = rej_reg;
        mem_re        = 1'b0;
        mem_raddr     = ptr_reg[IW-1:0];
        mem_we        = 1'b0;

        case (state_reg)
            swl_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = (func == swl_pkg::FUNC_START) ? '0 : ptr_reg[IW-1:0];
                    state_next = swl_pkg::ST_EVAL;
                end
            end

            swl_pkg::ST_EVAL:
            begin
                done_next     = 1'b1;
                sp_valid_next = 1'b0;
                sp_next       = '0;
                rej_next      = 1'b0;
                state_next    = swl_pkg::ST_IDLE;
                case (func_reg)
                    swl_pkg::FUNC_WRITE_ENTRY:
                    begin
                        if (walk_reg || idx_reg >= IW'(swl_pkg::STEP_SLOTS))
                        begin
                            rej_next = 1'b1;
                        end
                        else
                        begin
                            mem_we = 1'b1;
                        end
                    end
                    swl_pkg::FUNC_SET_LENGTH:
                    begin
                        if (walk_reg)
                        begin
                            rej_next = 1'b1;
                        end
                        else
                        begin
                            count_next = len_sat;
                        end
                    end
                    swl_pkg::FUNC_START:
                    begin
                        if (walk_reg || count_reg == '0)
                        begin
                            rej_next = 1'b1;
                        end
                        else
                        begin
                            walk_next     = 1'b1;
                            ptr_next      = '0;
                            sp_valid_next = 1'b1;
                            sp_next       = rd_data_reg;
                        end
                    end
                    swl_pkg::FUNC_STOP:
                    begin
                        if (!walk_reg)
                        begin
                            rej_next = 1'b1;
                        end
                        else
                        begin
                            walk_next = 1'b0;
                            ptr_next  = -SW'(1);
                        end
                    end
                    swl_pkg::FUNC_SAMPLE:
                    begin
                        if (walk_reg && reached)
                        begin
                            if (has_next)
                            begin
                                ptr_next   = ptr_inc;
                                mem_re     = 1'b1;
                                mem_raddr  = ptr_inc[IW-1:0];
                                done_next  = 1'b0;
                                state_next = swl_pkg::ST_NEXT;
                            end
                            else
                            begin
                                walk_next = 1'b0;
                                ptr_next  = -SW'(1);
                            end
                        end
                    end
                    default:
                    begin
                        rej_next = 1'b1;
                    end
                endcase
            end

            swl_pkg::ST_NEXT:
            begin
                done_next     = 1'b1;
                sp_valid_next = 1'b1;
                sp_next       = rd_data_reg;
                state_next    = swl_pkg::ST_IDLE;
            end

            default:
            begin
                state_next = swl_pkg::ST_IDLE;
            end
        endcase
    end

    assign done           = done_reg;
    assign setpoint_valid = sp_valid_reg;
    assign setpoint       = $signed(sp_reg);
    assign step_number    = ptr_reg;
    assign walking        = walk_reg;
    assign start_allowed  = !walk_reg;
    assign stop_allowed   = walk_reg;
    assign list_length    = count_reg;
    assign rejected       = rej_reg;

    a_done_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == swl_pkg::ST_IDLE))
        else $error("result strobe outside idle state");

    a_walk_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        walk_reg |-> (ptr_reg >= 0 && ptr_reg < $signed({1'b0, count_reg})))
        else $error("step pointer outside list while walking");

    a_stop_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        !walk_reg |-> (ptr_reg == -SW'(1)))
        else $error("step pointer not cleared while stopped");

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(swl_pkg::STEP_SLOTS))
        else $error("list length above maximum");

    a_setpoint_walking: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && sp_valid_reg) |-> walk_reg)
        else $error("setpoint issued while stopped");

    a_eval_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == swl_pkg::ST_IDLE && start) |=> (state_reg == swl_pkg::ST_EVAL))
        else $error("accepted transaction not evaluated");

endmodule

// ===== sim/setpoint_list_walker_tb.sv =====
`timescale 1ns / 100ps

module setpoint_list_walker_tb;

    localparam int unsigned FUNC_W     = swl_pkg::FUNC_W;
    localparam int unsigned INDEX_W    = swl_pkg::INDEX_W;
    localparam int unsigned VALUE_W    = swl_pkg::VALUE_W;
    localparam int unsigned REQ_W      = swl_pkg::REQ_W;
    localparam int unsigned STEP_W     = swl_pkg::STEP_W;
    localparam int unsigned COUNT_W    = swl_pkg::COUNT_W;
    localparam int unsigned TOL_W      = swl_pkg::TOL_W;
    localparam int unsigned STEP_SLOTS = swl_pkg::STEP_SLOTS;
    localparam logic [TOL_W-1:0] TOL_RESET = swl_pkg::TOL_RESET;

    localparam int FUNC_TOP = (1 << FUNC_W) - 1;
    localparam int QUIET_LIMIT = 2000;
    localparam logic signed [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam logic signed [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
    localparam logic signed [VALUE_W-1:0] NEAR = VALUE_W'(TOL_RESET);

    typedef struct packed {
        logic                       setpoint_valid;
        logic signed [VALUE_W-1:0]  setpoint;
        logic signed [STEP_W-1:0]   step_number;
        logic                       walking;
        logic                       start_allowed;
        logic                       stop_allowed;
        logic [COUNT_W-1:0]         list_length;
        logic                       rejected;
    } walk_result_t;

    class walk_tracker;
        logic [TOL_W-1:0]          tol;
        logic signed [VALUE_W-1:0] steps [STEP_SLOTS];
        bit                        written [STEP_SLOTS];
        int unsigned               count;
        int                        ptr;
        bit                        on_walk;
        walk_result_t              due [$];
        int                        errors;

        function new();
            tol = TOL_RESET;
            count = 0;
            ptr = -1;
            on_walk = 1'b0;
            errors = 0;
            foreach (written[i])
            begin
                written[i] = 1'b0;
                steps[i] = '0;
            end
        endfunction

        function bit start_safe();
            int last;
            int i;
            last = (count == 0) ? 0 : int'(count) - 1;
            for (i = 0; i <= last; i++)
            begin
                if (!written[i])
                    return 1'b0;
            end
            return 1'b1;
        endfunction

        function int first_gap();
            int i;
            for (i = 0; i < int'(count); i++)
            begin
                if (!written[i])
                    return i;
            end
            return -1;
        endfunction

        function void take_command(swl_pkg::func_t f, logic [INDEX_W-1:0] idx,
                                   logic signed [VALUE_W-1:0] val, logic [REQ_W-1:0] req);
            walk_result_t r;
            longint gap;
            r = '0;
            case (f)
                swl_pkg::FUNC_WRITE_ENTRY:
                begin
                    if (on_walk || idx >= STEP_SLOTS)
                        r.rejected = 1'b1;
                    else
                    begin
                        steps[idx] = val;
                        written[idx] = 1'b1;
                    end
                end
                swl_pkg::FUNC_SET_LENGTH:
                begin
                    if (on_walk)
                        r.rejected = 1'b1;
                    else
                        count = (req > STEP_SLOTS) ? STEP_SLOTS : req;
                end
                swl_pkg::FUNC_START:
                begin
                    if (on_walk || count == 0)
                        r.rejected = 1'b1;
                    else
                    begin
                        on_walk = 1'b1;
                        ptr = 0;
                        r.setpoint_valid = 1'b1;
                        r.setpoint = steps[0];
                    end
                end
                swl_pkg::FUNC_STOP:
                begin
                    if (!on_walk)
                        r.rejected = 1'b1;
                    else
                    begin
                        on_walk = 1'b0;
                        ptr = -1;
                    end
                end
                swl_pkg::FUNC_SAMPLE:
                begin
                    if (on_walk)
                    begin
                        gap = longint'(val) - longint'(steps[ptr]);
                        if (gap < 0)
                            gap = -gap;
                        if (gap <= longint'(tol))
                        begin
                            ptr++;
                            if (ptr < int'(count))
                            begin
                                r.setpoint_valid = 1'b1;
                                r.setpoint = steps[ptr];
                            end
                            else
                            begin
                                on_walk = 1'b0;
                                ptr = -1;
                            end
                        end
                    end
                end
                default:
                    r.rejected = 1'b1;
            endcase
            r.step_number = STEP_W'(ptr);
            r.walking = on_walk;
            r.start_allowed = !on_walk;
            r.stop_allowed = on_walk;
            r.list_length = COUNT_W'(count);
            due.push_back(r);
        endfunction

        function string show(walk_result_t r);
            return $sformatf({"sv=%0d sp=%0d step=%0d walk=%0d",
                              " start_ok=%0d stop_ok=%0d len=%0d rej=%0d"},
                             r.setpoint_valid, r.setpoint, r.step_number, r.walking,
                             r.start_allowed, r.stop_allowed, r.list_length, r.rejected);
        endfunction

        function void match_result(walk_result_t got);
            walk_result_t exp;
            string bad;
            if (due.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: %s", show(got));
                return;
            end
            exp = due.pop_front();
            bad = "";
            if (got.setpoint_valid !== exp.setpoint_valid) bad = {bad, " setpoint_valid"};
            if (got.setpoint !== exp.setpoint)             bad = {bad, " setpoint"};
            if (got.step_number !== exp.step_number)       bad = {bad, " step_number"};
            if (got.walking !== exp.walking)               bad = {bad, " walking"};
            if (got.start_allowed !== exp.start_allowed)   bad = {bad, " start_allowed"};
            if (got.stop_allowed !== exp.stop_allowed)     bad = {bad, " stop_allowed"};
            if (got.list_length !== exp.list_length)       bad = {bad, " list_length"};
            if (got.rejected !== exp.rejected)             bad = {bad, " rejected"};
            if (bad != "")
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch in%s\n  expected: %s\n  actual:   %s",
                             bad, show(exp), show(got));
            end
        endfunction
    endclass

    logic                       clk;
    logic                       rst_n;
    logic                       start;
    logic                       busy;
    swl_pkg::func_t             func;
    logic [INDEX_W-1:0]         entry_index;
    logic signed [VALUE_W-1:0]  value;
    logic [REQ_W-1:0]           length_request;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [TOL_W-1:0]           cfg_data;
    logic                       done;
    logic                       setpoint_valid;
    logic signed [VALUE_W-1:0]  setpoint;
    logic signed [STEP_W-1:0]   step_number;
    logic                       walking;
    logic                       start_allowed;
    logic                       stop_allowed;
    logic [COUNT_W-1:0]         list_length;
    logic                       rejected;

    walk_tracker  tracker;
    walk_result_t seen;

    setpoint_list_walker dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .func           (func),
        .entry_index    (entry_index),
        .value          (value),
        .length_request (length_request),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .done           (done),
        .setpoint_valid (setpoint_valid),
        .setpoint       (setpoint),
        .step_number    (step_number),
        .walking        (walking),
        .start_allowed  (start_allowed),
        .stop_allowed   (stop_allowed),
        .list_length    (list_length),
        .rejected       (rejected)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            seen.setpoint_valid = setpoint_valid;
            seen.setpoint = setpoint;
            seen.step_number = step_number;
            seen.walking = walking;
            seen.start_allowed = start_allowed;
            seen.stop_allowed = stop_allowed;
            seen.list_length = list_length;
            seen.rejected = rejected;
            tracker.match_result(seen);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((start && !busy) || done || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    task automatic send(swl_pkg::func_t f, logic [INDEX_W-1:0] idx,
                        logic signed [VALUE_W-1:0] val, logic [REQ_W-1:0] req);
        start <= 1'b1;
        func <= f;
        entry_index <= idx;
        value <= val;
        length_request <= req;
        do @(posedge clk); while (busy);
        tracker.take_command(f, idx, val, req);
    endtask

    // hold off until every transaction in flight has returned
    task automatic drain();
        start <= 1'b0;
        do @(posedge clk); while (tracker.due.size() != 0);
    endtask

    task automatic set_tolerance(logic [TOL_W-1:0] tol);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= tol;
        do @(posedge clk); while (!cfg_ready);
        tracker.tol = tol;
        cfg_valid <= 1'b0;
    endtask

    task automatic pick(output swl_pkg::func_t f, output logic [INDEX_W-1:0] idx,
                        output logic signed [VALUE_W-1:0] val, output logic [REQ_W-1:0] req);
        int roll;
        int g;
        longint tgt;
        longint lim;
        longint off;
        longint v;
        roll = $urandom_range(99, 0);
        idx = INDEX_W'($urandom);
        val = VALUE_W'($urandom);
        req = REQ_W'($urandom);
        f = swl_pkg::FUNC_SAMPLE;
        if (tracker.on_walk)
        begin
            tgt = longint'(tracker.steps[tracker.ptr]);
            lim = longint'(tracker.tol);
            if (roll < 55)
            begin
                off = ($urandom_range(4, 0) == 0)
                    ? lim : longint'($urandom_range(tracker.tol, 0));
                v = ($urandom_range(1, 0) == 1) ? tgt + off : tgt - off;
                if (v > longint'(VAL_MAX))
                    v = longint'(VAL_MAX);
                if (v < longint'(VAL_MIN))
                    v = longint'(VAL_MIN);
                val = VALUE_W'(v);
            end
            else if (roll < 75)
            begin
                off = lim + 1 + longint'($urandom_range(64, 0));
                if (tgt + off <= longint'(VAL_MAX))
                    val = VALUE_W'(tgt + off);
                else if (tgt - off >= longint'(VAL_MIN))
                    val = VALUE_W'(tgt - off);
            end
            else if (roll < 88)
                f = swl_pkg::FUNC_STOP;
            else if (roll >= 80)
                f = swl_pkg::func_t'($urandom_range(FUNC_TOP, 0));
        end
        else
        begin
            if (tracker.count > 0 && tracker.start_safe() && roll < 40)
                f = swl_pkg::FUNC_START;
            else if (roll < 55)
            begin
                f = swl_pkg::FUNC_SET_LENGTH;
                if ($urandom_range(3, 0) != 0)
                    req = REQ_W'($urandom_range(6, 1));
            end
            else if (roll < 65)
                f = swl_pkg::func_t'($urandom_range(FUNC_TOP, 0));
            else
            begin
                f = swl_pkg::FUNC_WRITE_ENTRY;
                g = tracker.first_gap();
                if (g >= 0 && $urandom_range(3, 0) != 0)
                    idx = INDEX_W'(g);
                if ($urandom_range(99, 0) < 15)
                begin
                    case ($urandom_range(3, 0))
                        0: val = VAL_MAX;
                        1: val = VAL_MIN;
                        2: val = '0;
                        default: val = '1;
                    endcase
                end
            end
            // never start on a list that still has unwritten entries
            if (f == swl_pkg::FUNC_START && !tracker.start_safe())
                f = swl_pkg::FUNC_STOP;
        end
    endtask

    task automatic run_phase(int n, int idle_pct);
        swl_pkg::func_t f;
        logic [INDEX_W-1:0] idx;
        logic signed [VALUE_W-1:0] val;
        logic [REQ_W-1:0] req;
        int k;
        for (k = 0; k < n; k++)
        begin
            pick(f, idx, val, req);
            send(f, idx, val, req);
            if ($urandom_range(99, 0) < 2)
                drain();
            else if (idle_pct > 0 && $urandom_range(99, 0) < idle_pct)
            begin
                start <= 1'b0;
                do @(posedge clk); while ($urandom_range(99, 0) < idle_pct);
            end
        end
    endtask

    initial
    begin
        int c;
        tracker = new();
        rst_n = 1'b0;
        start = 1'b0;
        func = swl_pkg::FUNC_WRITE_ENTRY;
        entry_index = '0;
        value = '0;
        length_request = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(swl_pkg::FUNC_STOP, '0, '0, '0);
        send(swl_pkg::FUNC_SAMPLE, '0, VAL_MIN, '0);
        for (c = int'(swl_pkg::FUNC_SAMPLE) + 1; c <= FUNC_TOP; c++)
            send(swl_pkg::func_t'(c), '1, '1, '1);
        send(swl_pkg::FUNC_WRITE_ENTRY, '1, VAL_MAX, '0);
        send(swl_pkg::FUNC_WRITE_ENTRY, INDEX_W'(STEP_SLOTS), VAL_MAX, '0);
        send(swl_pkg::FUNC_WRITE_ENTRY, '0, VAL_MAX, '0);
        send(swl_pkg::FUNC_START, '0, '0, '0);
        send(swl_pkg::FUNC_SET_LENGTH, '0, '0, '1);
        send(swl_pkg::FUNC_SET_LENGTH, '0, '0, '0);
        send(swl_pkg::FUNC_WRITE_ENTRY, INDEX_W'(1), VAL_MIN, '0);
        send(swl_pkg::FUNC_WRITE_ENTRY, INDEX_W'(STEP_SLOTS - 1), '1, '0);
        send(swl_pkg::FUNC_WRITE_ENTRY, INDEX_W'(2), '0, '0);
        send(swl_pkg::FUNC_SET_LENGTH, '0, '0, REQ_W'(3));
        send(swl_pkg::FUNC_START, '0, '0, '0);
        send(swl_pkg::FUNC_WRITE_ENTRY, INDEX_W'(3), VAL_MAX, '0);
        send(swl_pkg::FUNC_SET_LENGTH, '0, '0, REQ_W'(1));
        send(swl_pkg::FUNC_START, '0, '0, '0);
        send(swl_pkg::FUNC_SAMPLE, '0, VAL_MIN, '0);
        send(swl_pkg::FUNC_SAMPLE, '0, VAL_MAX - NEAR, '0);
        send(swl_pkg::FUNC_SAMPLE, '0, VAL_MIN + NEAR, '0);
        send(swl_pkg::FUNC_SAMPLE, '0, NEAR + 1, '0);
        send(swl_pkg::FUNC_SAMPLE, '0, -NEAR, '0);
        send(swl_pkg::FUNC_START, '0, '0, '0);
        send(swl_pkg::FUNC_STOP, '0, '0, '0);

        set_tolerance('0);
        run_phase(132, 0);
        set_tolerance('1);
        run_phase(132, 58);
        set_tolerance(TOL_W'($urandom_range(4000, 1)));
        run_phase(132, 0);
        set_tolerance(TOL_RESET);
        run_phase(132, 22);

        drain();
        repeat (10) @(posedge clk);
        if (tracker.errors == 0 && tracker.due.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== setpoint_list_walker.f =====
design/swl_pkg.sv
design/setpoint_list_walker.sv
sim/setpoint_list_walker_tb.sv
